### sv/dq_pkg.sv
// Shared constants, codes and types for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 64;

	// port widths of the command and result fields
	localparam int OPC_W   = 3;
	localparam int IO_W    = 64;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int SUM_W   = CNT_W + 1;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_BACK  = 3'd5,
		OP_CLEAR      = 3'd6,
		OP_NOP        = 3'd7
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;   // latch the command on an input transfer
		logic exec;      // ring update, store access
		logic load_out;  // move the result into the output register
	} dq_cmd_t;

endpackage

### sv/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
// Flow: a command transferred in idle is captured, runs the store access step and is
//   then loaded into the output register; out_stall can hold this last step, and no
//   new command is taken until the load.
// Reset: arst_n clears state, head pointer, occupancy and output valid at once;
//   the entry store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module double_ended_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [dq_pkg::OPC_W-1:0]  opcode,
	input  logic [dq_pkg::IO_W-1:0]   entry_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [dq_pkg::STAT_W-1:0] status,
	output logic [dq_pkg::IO_W-1:0]   read_data,
	output logic [dq_pkg::CNT_W-1:0]  entry_count
);
	import dq_pkg::*;

	// command bundle from controller to datapath
	dq_cmd_t cmd;

	// Controller: takes one transfer in idle, then runs the store access step
	// and waits for the output register to free before loading the result.
	// A new command may be taken while a finished result still waits.
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: ring of DEPTH slots, head pointer, occupancy, result registers.
	// Ring indexing wraps with a single compare, so any depth works.
	dq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.entry_data  (entry_data),
		.status      (status),
		.read_data   (read_data),
		.entry_count (entry_count)
	);

endmodule

### sv/dq_ctrl.sv
// Sequencing state machine and channel handshakes for the double-ended queue.
`timescale 1ns / 1ps
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output dq_pkg::dq_cmd_t cmd
);
	import dq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	// output register free, or emptied at this edge
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n      = state_q;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_n  = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/dq_datapath.sv
// Ring pointers, entry store and result registers of the double-ended queue.
`timescale 1ns / 1ps
module dq_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dq_pkg::dq_cmd_t           cmd,
	input  logic [dq_pkg::OPC_W-1:0]  opcode,
	input  logic [dq_pkg::IO_W-1:0]   entry_data,
	output logic [dq_pkg::STAT_W-1:0] status,
	output logic [dq_pkg::IO_W-1:0]   read_data,
	output logic [dq_pkg::CNT_W-1:0]  entry_count
);
	import dq_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	opcode_t               op_q;
	logic [DATA_WIDTH-1:0] wdata_q;
	logic [PTR_W-1:0]      head_q, head_n;
	logic [CNT_W-1:0]      occ_q, occ_n;
	logic [DATA_WIDTH-1:0] rd_q;
	status_t               res_stat_q, res_stat_n;
	logic                  hit_q, hit_n;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	logic [CNT_W-1:0]      entry_count_q;

	logic                  wr_en, rd_en;
	logic [PTR_W-1:0]      wr_addr, rd_addr;
	logic                  full, empty;
	logic [PTR_W-1:0]      head_dec, head_inc, tail_wr, tail_rd;

	// sum below twice the depth: one compare and subtract
	function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
		logic [SUM_W-1:0] r;
		r = s;
		if (s >= SUM_W'(DEPTH))
			r = s - SUM_W'(DEPTH);
		return r[PTR_W-1:0];
	endfunction

	assign full     = (occ_q >= CNT_W'(DEPTH));
	assign empty    = (occ_q == '0);
	assign head_dec = ring_wrap(SUM_W'(head_q) + SUM_W'(DEPTH - 1));
	assign head_inc = ring_wrap(SUM_W'(head_q) + SUM_W'(1));
	assign tail_wr  = ring_wrap(SUM_W'(head_q) + SUM_W'(occ_q));
	assign tail_rd  = ring_wrap(SUM_W'(head_q) + SUM_W'(occ_q) - SUM_W'(1));

	always_comb begin
		head_n     = head_q;
		occ_n      = occ_q;
		res_stat_n = ST_OK;
		hit_n      = 1'b0;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		wr_addr    = tail_wr;
		rd_addr    = head_q;
		case (op_q)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					res_stat_n = ST_FULL;
				end else begin
					wr_en = 1'b1;
					occ_n = occ_q + CNT_W'(1);
					if (op_q == OP_PUSH_FRONT) begin
						wr_addr = head_dec;
						head_n  = head_dec;
					end
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (empty) begin
					res_stat_n = ST_EMPTY;
				end else begin
					rd_en = 1'b1;
					hit_n = 1'b1;
					if (op_q == OP_POP_FRONT) begin
						head_n = head_inc;
						occ_n  = occ_q - CNT_W'(1);
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (empty) begin
					res_stat_n = ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					hit_n   = 1'b1;
					rd_addr = tail_rd;
					if (op_q == OP_POP_BACK)
						occ_n = occ_q - CNT_W'(1);
				end
			end
			OP_CLEAR: begin
				head_n = '0;
				occ_n  = '0;
			end
			default: ;
		endcase
	end

	// entry store: one write or one registered read per command
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en)
			mem_q[wr_addr] <= wdata_q;
		if (cmd.exec && rd_en)
			rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode_t'(opcode);
			wdata_q <= entry_data[DATA_WIDTH-1:0];
		end
		if (cmd.exec) begin
			res_stat_q <= res_stat_n;
			hit_q      <= hit_n;
		end
		if (cmd.load_out) begin
			status_q      <= res_stat_q;
			read_data_q   <= hit_q ? rd_q : '0;
			entry_count_q <= occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else if (cmd.exec) begin
			head_q <= head_n;
			occ_q  <= occ_n;
		end
	end

	assign status      = status_q;
	assign read_data   = IO_W'(read_data_q);
	assign entry_count = entry_count_q;

endmodule

### sv/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`timescale 1ns / 1ps
module dq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [dq_pkg::STAT_W-1:0] status,
	input logic [dq_pkg::IO_W-1:0]   read_data,
	input logic [dq_pkg::CNT_W-1:0]  entry_count
);
	import dq_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status)
			&& $stable(entry_count))
		else $error("stalled result changed");

	// one command at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("command taken while busy");

	// errors never return data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_W'(ST_OK) |-> read_data == '0)
		else $error("error result carries data");

	// full status only at full occupancy, empty only at zero
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_W'(ST_FULL) |-> entry_count == CNT_W'(DEPTH))
		else $error("full status with free slots");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_W'(ST_EMPTY) |-> entry_count == '0)
		else $error("empty status with entries held");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

### tb/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue: directed and random command streams.
`timescale 1ns / 1ps
module double_ended_queue_tb;
	import dq_pkg::*;

	// generous watchdog for ~1100 commands with idle gaps and back-pressure
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [IO_W-1:0] DATA_MASK = {IO_W{1'b1}} >> (IO_W - DATA_WIDTH);

	typedef struct {
		logic [STAT_W-1:0] st;
		logic [IO_W-1:0]   rd;
		logic [CNT_W-1:0]  cnt;
	} dq_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [OPC_W-1:0]  opcode = OP_NOP;
	logic [IO_W-1:0]   entry_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [IO_W-1:0]   read_data;
	logic [CNT_W-1:0]  entry_count;

	// mirror of the queue contents
	logic [IO_W-1:0]  mirror_ring [DEPTH];
	int unsigned      mirror_head = 0;
	int unsigned      mirror_fill = 0;

	dq_result_t expected_results [$];
	int         mismatches = 0;
	int         cycles = 0;
	bit         idling_on = 1'b0;

	double_ended_queue i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.entry_data  (entry_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_data   (read_data),
		.entry_count (entry_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [IO_W-1:0] got, logic [IO_W-1:0] want);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Works out the result of one command and advances the mirror.
	function automatic dq_result_t predict_queue_result(logic [OPC_W-1:0] op,
			logic [IO_W-1:0] data);
		dq_result_t  res;
		int unsigned slot;
		res.st = ST_OK;
		res.rd = '0;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (mirror_fill >= DEPTH) begin
					res.st = ST_FULL;
				end else if (op == OP_PUSH_FRONT) begin
					mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
					mirror_ring[mirror_head] = data & DATA_MASK;
					mirror_fill++;
				end else begin
					slot = (mirror_head + mirror_fill) % DEPTH;
					mirror_ring[slot] = data & DATA_MASK;
					mirror_fill++;
				end
			end
			OP_POP_FRONT, OP_PEEK_FRONT: begin
				if (mirror_fill == 0) begin
					res.st = ST_EMPTY;
				end else begin
					res.rd = mirror_ring[mirror_head];
					if (op == OP_POP_FRONT) begin
						mirror_head = (mirror_head + 1) % DEPTH;
						mirror_fill--;
					end
				end
			end
			OP_POP_BACK, OP_PEEK_BACK: begin
				if (mirror_fill == 0) begin
					res.st = ST_EMPTY;
				end else begin
					slot = (mirror_head + mirror_fill - 1) % DEPTH;
					res.rd = mirror_ring[slot];
					if (op == OP_POP_BACK)
						mirror_fill--;
				end
			end
			OP_CLEAR: begin
				mirror_head = 0;
				mirror_fill = 0;
			end
			default: ;
		endcase
		res.rd  = res.rd & DATA_MASK;
		res.cnt = mirror_fill[CNT_W-1:0];
		return res;
	endfunction

	// One command transfer. Entered and left at a falling edge; in_valid stays high
	// across back-to-back commands so it never gets two updates in one step.
	task automatic send_command(logic [OPC_W-1:0] op, logic [IO_W-1:0] data);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		entry_data <= data;
		do
			@(posedge clk);
		while (in_stall);
		expected_results.push_back(predict_queue_result(op, data));
		@(negedge clk);
	endtask

	// Sender holds off until every outstanding result is back.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	// Receiver back-pressure in bursts.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		dq_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", {62'd0, status}, '0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", {62'd0, status}, {62'd0, want.st});
				if (read_data !== want.rd)
					report_mismatch("read_data", read_data, want.rd);
				if (entry_count !== want.cnt)
					report_mismatch("entry_count", {59'd0, entry_count}, {59'd0, want.cnt});
			end
		end
	end

	function automatic logic [IO_W-1:0] random_entry();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// push_pct biases the stream towards filling or draining the queue
	function automatic logic [OPC_W-1:0] random_opcode(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
		else if (r < 97)
			case ($urandom_range(0, 3))
				0:       return OP_POP_FRONT;
				1:       return OP_POP_BACK;
				2:       return OP_PEEK_FRONT;
				default: return OP_PEEK_BACK;
			endcase
		else if (r < 99)
			return OP_NOP;
		else
			return OP_CLEAR;
	endfunction

	// Pops and peeks on an empty queue, no-op and clear with nothing held.
	task automatic test_empty_queue();
		send_command(OP_POP_FRONT, '1);
		send_command(OP_POP_BACK, '0);
		send_command(OP_PEEK_FRONT, '1);
		send_command(OP_PEEK_BACK, '0);
		send_command(OP_NOP, '1);
		send_command(OP_CLEAR, '1);
	endtask

	// Fill from both ends, reject pushes when full, then peek, pop, no-op, clear and peek the cleared queue.
	task automatic test_full_queue();
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0:       send_command(OP_PUSH_BACK, '1);
				1:       send_command(OP_PUSH_FRONT, '0);
				2:       send_command(OP_PUSH_BACK, {32{2'b01}});
				default: send_command(OP_PUSH_FRONT, {32{2'b10}});
			endcase
		end
		send_command(OP_PUSH_FRONT, '1);
		send_command(OP_PUSH_BACK, '1);
		send_command(OP_PEEK_FRONT, '0);
		send_command(OP_PEEK_BACK, '0);
		send_command(OP_POP_FRONT, '0);
		send_command(OP_POP_BACK, '0);
		send_command(OP_NOP, '0);
		send_command(OP_CLEAR, '0);
		send_command(OP_PEEK_BACK, '0);
	endtask

	// Runs of fill-biased, drain-biased and balanced commands so that the ring
	// wraps and hits both full and empty many times; vary_idling lets idling
	// switch on and off between runs.
	task automatic test_random_traffic(int n_items, bit vary_idling);
		int bias;
		int run;
		int sent;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 2))
				0:       bias = 80;
				1:       bias = 20;
				default: bias = 50;
			endcase
			run = $urandom_range(10, 50);
			for (int i = 0; i < run && sent < n_items; i++) begin
				send_command(random_opcode(bias), random_entry());
				sent++;
			end
			if (vary_idling && $urandom_range(0, 3) == 0)
				idling_on = !idling_on;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_queue();
		idling_on = 1'b1;
		test_full_queue();
		test_random_traffic(450, 1'b1);
		wait_for_results();
		test_random_traffic(450, 1'b1);
		// last stretch at full rate, no gaps on either side
		idling_on = 1'b0;
		test_random_traffic(100, 1'b0);
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
